>>> sv/bcc_pkg.sv
package bcc_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD  = 3'd4;

  // Register reset values.
  localparam logic [7:0]  DEBOUNCE_RST    = 8'd30;
  localparam logic [15:0] CLICK_MAX_RST   = 16'd400;
  localparam logic [15:0] SINGLE_WAIT_RST = 16'd300;
  localparam logic [15:0] WARN_RST        = 16'd5000;
  localparam logic [15:0] RESET_HOLD_RST  = 16'd10000;

  // Click event codes.
  localparam logic [1:0] CLICK_NONE   = 2'd0;
  localparam logic [1:0] CLICK_SINGLE = 2'd1;
  localparam logic [1:0] CLICK_DOUBLE = 2'd2;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] click_max_ticks;
    logic [15:0] single_wait_ticks;
    logic [15:0] warn_ticks;
    logic [15:0] reset_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic        previous_raw;
    logic        accepted_level;
    logic [7:0]  stable_count;
    logic [15:0] hold_count;
    logic        hold_valid;
    logic        single_pending;
    logic [15:0] single_count;
    logic        warned_flag;
    logic        triggered_flag;
    logic        release_wait_flag;
    logic        reboot_flag;
  } state_t;

  typedef struct packed {
    logic       debounced_level;
    logic [1:0] click_event;
    logic       hold_warning;
    logic       credential_reset;
    logic       reboot_request;
    logic       awaiting_release;
  } result_t;

endpackage

>>> sv/bcc_if.sv
interface bcc_in_if;
  logic valid;
  logic ready;
  logic raw_pressed;

  modport source (output valid, output raw_pressed, input ready);
  modport sink   (input valid, input raw_pressed, output ready);
endinterface

interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic       debounced_level;
  logic [1:0] click_event;
  logic       hold_warning;
  logic       credential_reset;
  logic       reboot_request;
  logic       awaiting_release;

  modport source (output valid, output debounced_level, output click_event,
                  output hold_warning, output credential_reset,
                  output reboot_request, output awaiting_release, input ready);
  modport sink   (input valid, input debounced_level, input click_event,
                  input hold_warning, input credential_reset,
                  input reboot_request, input awaiting_release, output ready);
endinterface

>>> sv/bcc_step.sv
module bcc_step (
  input  bcc_pkg::cfg_t    cfg,
  input  bcc_pkg::state_t  st,
  input  logic             raw,
  output bcc_pkg::state_t  st_next,
  output bcc_pkg::result_t res
);

  always_comb begin
    bcc_pkg::state_t s;
    logic [1:0]      click;
    logic            warn_pulse;
    logic            reset_pulse;

    s           = st;
    click       = bcc_pkg::CLICK_NONE;
    warn_pulse  = 1'b0;
    reset_pulse = 1'b0;

    // Elapsed-time counters saturate at all ones.
    if (s.hold_valid && (s.hold_count != 16'hFFFF)) begin
      s.hold_count = s.hold_count + 16'd1;
    end
    if (s.single_pending && (s.single_count != 16'hFFFF)) begin
      s.single_count = s.single_count + 16'd1;
    end

    if (raw != s.previous_raw) begin
      s.stable_count = 8'd0;
    end else if (s.stable_count != 8'hFF) begin
      s.stable_count = s.stable_count + 8'd1;
    end

    // Debounced edge.
    if ((s.stable_count >= cfg.debounce_ticks) && (raw != s.accepted_level)) begin
      s.accepted_level = raw;
      if (raw) begin
        s.hold_count = 16'd0;
        s.hold_valid = 1'b1;
      end else if (s.release_wait_flag || s.triggered_flag) begin
        s.hold_valid = 1'b0;
      end else if (s.hold_valid) begin
        s.hold_valid = 1'b0;
        if ((s.hold_count >= cfg.warn_ticks) || (s.hold_count > cfg.click_max_ticks)) begin
          s.single_pending = 1'b0;
        end else if (s.single_pending) begin
          s.single_pending = 1'b0;
          click = bcc_pkg::CLICK_DOUBLE;
        end else begin
          s.single_pending = 1'b1;
          s.single_count   = 16'd0;
        end
      end
    end
    s.previous_raw = raw;

    // Hold supervision.
    if (!s.accepted_level) begin
      if (s.release_wait_flag) begin
        s.reboot_flag       = 1'b1;
        s.release_wait_flag = 1'b0;
      end
      s.hold_valid     = 1'b0;
      s.warned_flag    = 1'b0;
      s.triggered_flag = 1'b0;
    end else if (!s.release_wait_flag) begin
      if (!s.hold_valid) begin
        s.hold_valid = 1'b1;
        s.hold_count = 16'd0;
      end else begin
        if (!s.warned_flag && (s.hold_count >= cfg.warn_ticks)) begin
          s.single_pending = 1'b0;
          s.warned_flag    = 1'b1;
          warn_pulse       = 1'b1;
        end
        if (!s.triggered_flag && (s.hold_count >= cfg.reset_hold_ticks)) begin
          s.triggered_flag    = 1'b1;
          s.release_wait_flag = 1'b1;
          s.single_pending    = 1'b0;
          reset_pulse         = 1'b1;
        end
      end
    end

    // Pending single click times out into a single-click event.
    if (s.single_pending && (s.single_count >= cfg.single_wait_ticks)) begin
      s.single_pending = 1'b0;
      click = bcc_pkg::CLICK_SINGLE;
    end

    st_next                  = s;
    res.debounced_level      = s.accepted_level;
    res.click_event          = click;
    res.hold_warning         = warn_pulse;
    res.credential_reset     = reset_pulse;
    res.reboot_request       = s.reboot_flag;
    res.awaiting_release     = s.release_wait_flag;
  end

endmodule

>>> sv/button_click_and_hold_classifier_core.sv
// Latency: a result word is valid in the cycle after its sample word is accepted.
// Throughput: one sample word per cycle while the result word is taken; the whole tick update is one pass of
// small compare and increment logic between the state registers and the result register.
// Reset (rst, synchronous, active high): all classifier state clears, the
// configuration registers return to their defaults and the result register empties.
module button_click_and_hold_classifier_core (
  input  logic                              clk,
  input  logic                              rst,
  bcc_in_if.sink                            in_ch,
  bcc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  bcc_pkg::cfg_t    cfg;
  bcc_pkg::state_t  st;
  bcc_pkg::state_t  st_next;
  bcc_pkg::result_t res_next;
  bcc_pkg::result_t res;
  logic             out_valid;
  logic             in_fire;

  // The result register is a single pipeline stage: a new sample word is taken
  // whenever the stage is empty or its word is being taken in the same cycle.
  assign in_ch.ready = !rst && (!out_valid || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration registers. Writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= bcc_pkg::DEBOUNCE_RST;
      cfg.click_max_ticks   <= bcc_pkg::CLICK_MAX_RST;
      cfg.single_wait_ticks <= bcc_pkg::SINGLE_WAIT_RST;
      cfg.warn_ticks        <= bcc_pkg::WARN_RST;
      cfg.reset_hold_ticks  <= bcc_pkg::RESET_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcc_pkg::REG_DEBOUNCE:    cfg.debounce_ticks    <= cfg_wdata[7:0];
        bcc_pkg::REG_CLICK_MAX:   cfg.click_max_ticks   <= cfg_wdata;
        bcc_pkg::REG_SINGLE_WAIT: cfg.single_wait_ticks <= cfg_wdata;
        bcc_pkg::REG_WARN:        cfg.warn_ticks        <= cfg_wdata;
        bcc_pkg::REG_RESET_HOLD:  cfg.reset_hold_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The per-tick update: debounce, edge classification, hold supervision and
  // the single-click timeout, all from the current state and the new sample.
  bcc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .raw     (in_ch.raw_pressed),
    .st_next (st_next),
    .res     (res_next)
  );

  // Classifier state advances only on an accepted sample word.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.debounced_level  = res.debounced_level;
  assign out_ch.click_event      = res.click_event;
  assign out_ch.hold_warning     = res.hold_warning;
  assign out_ch.credential_reset = res.credential_reset;
  assign out_ch.reboot_request   = res.reboot_request;
  assign out_ch.awaiting_release = res.awaiting_release;

endmodule

>>> sv/bcc_checker.sv
module bcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] click_event,
  input logic       hold_warning,
  input logic       credential_reset,
  input logic       reboot_request,
  input logic       awaiting_release
);

  logic seen_reboot;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_reboot <= 1'b0;
    end else if (out_valid && out_ready && reboot_request) begin
      seen_reboot <= 1'b1;
    end
  end

  // A waiting result word holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(click_event) &&
      $stable(reboot_request) && $stable(awaiting_release))
    else $error("stalled result word changed");

  // An empty or draining result stage must take a new sample word.
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("sample word refused while result stage is free");

  // A credential reset pulse always starts the wait for release.
  a_reset_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && credential_reset |-> awaiting_release && !hold_warning ||
      out_valid && credential_reset && awaiting_release)
    else $error("credential reset without release wait");

  // Reboot request is sticky until reset.
  a_reboot_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_reboot |-> reboot_request)
    else $error("reboot request dropped");

  // A sample word accepted now yields a result word in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid && click_event != 2'd3)
    else $error("missing or malformed result word");

endmodule

bind button_click_and_hold_classifier_core bcc_checker u_bcc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .click_event      (out_ch.click_event),
  .hold_warning     (out_ch.hold_warning),
  .credential_reset (out_ch.credential_reset),
  .reboot_request   (out_ch.reboot_request),
  .awaiting_release (out_ch.awaiting_release)
);
